[design/cpcr_pkg.sv]
// Package for the circle pair collision resolve unit: widths, item types, helpers.
`timescale 1ns / 1ps
`default_nettype none
package cpcr_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int W    = COORD_WIDTH;
    localparam int D2W  = 2 * W + 1;   // squared distance
    localparam int RW   = W + 1;       // integer root of squared distance
    localparam int QW   = W - 1;       // per-axis shift magnitude
    localparam int DENW = W + 2;       // twice the distance
    localparam int NUMW = 2 * W;       // magnitude times overlap

    typedef struct packed {
        logic signed [W-1:0] first_x;
        logic signed [W-1:0] first_y;
        logic        [W-2:0] first_radius;
        logic signed [W-1:0] second_x;
        logic signed [W-1:0] second_y;
        logic        [W-2:0] second_radius;
    } t_in;

    typedef struct packed {
        logic                touching;
        logic signed [W-1:0] new_first_x;
        logic signed [W-1:0] new_first_y;
        logic signed [W-1:0] new_second_x;
        logic signed [W-1:0] new_second_y;
    } t_out;

    // Per-item data that rides beside the root and divide pipelines
    typedef struct packed {
        logic         touch;
        logic         move;
        logic         neg_x;
        logic         neg_y;
        logic [W-1:0] ax;
        logic [W-1:0] ay;
        logic [W-1:0] bx;
        logic [W-1:0] by;
        logic [W-1:0] mx;
        logic [W-1:0] my;
        logic [W-1:0] s;
    } t_side;

    // Clamp a W+1 bit signed sum to the signed W bit range
    function automatic logic [W-1:0] sat_coord(input logic [W:0] v);
        logic [W-1:0] r;
        if (v[W] != v[W-1]) begin
            r = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[design/circle_pair_collision_resolve_unit.sv]
// Top level of the circle pair collision resolve unit.
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+------------------------------------
//  input    | i_start, i_item, o_busy    | taken when i_start high, o_busy low
//  result   | o_valid, o_result          | one cycle strobe, cannot be held off
//
// One item enters per cycle; each result passes through 5 front stages, 25 root stages,
// overlap, multiply, 23 divide stages and the output register.
// The root and divide pipelines each produce one bit per stage.
// o_busy is always low: the pipeline never stalls.
// Reset clears the valid bits only; payload in flight is dropped.
`timescale 1ns / 1ps
`default_nettype none
module circle_pair_collision_resolve_unit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire cpcr_pkg::t_in   i_item,
    output logic                 o_busy,
    output logic                 o_valid,
    output cpcr_pkg::t_out       o_result
);
    import cpcr_pkg::*;

    localparam int LAT = 5 + RW + 2 + QW + 1;

    logic            f_valid;
    t_side           f_side;
    logic [D2W-1:0]  f_d2;
    logic [RW-1:0]   w_dist;
    logic [QW-1:0]   w_qx, w_qy;

    logic [RW-1:0]   r_sq_v;
    t_side           r_sq_side [RW];
    logic            r_o_v, r_m_v;
    t_side           r_o_side, r_m_side;
    logic [RW-1:0]   r_o_dist;
    logic [W-1:0]    r_o_ov;
    logic [NUMW-1:0] r_m_nx, r_m_ny;
    logic [DENW-1:0] r_m_den;
    logic [QW-1:0]   r_dv_v;
    t_side           r_dv_side [QW];
    logic            r_out_v;
    t_out            r_out, n_out;
    logic [W:0]      n_px, n_py;

    cpcr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start & ~o_busy),
        .i_item  (i_item),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_d2    (f_d2)
    );

    cpcr_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (f_d2),
        .o_root (w_dist)
    );

    cpcr_div u_div_x (
        .i_clk (i_clk),
        .i_num (r_m_nx),
        .i_den (r_m_den),
        .o_quo (w_qx)
    );

    cpcr_div u_div_y (
        .i_clk (i_clk),
        .i_num (r_m_ny),
        .i_den (r_m_den),
        .o_quo (w_qy)
    );

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v  <= '0;
            r_o_v   <= 1'b0;
            r_m_v   <= 1'b0;
            r_dv_v  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_sq_v  <= {r_sq_v[RW-2:0], f_valid};
            r_o_v   <= r_sq_v[RW-1];
            r_m_v   <= r_o_v;
            r_dv_v  <= {r_dv_v[QW-2:0], r_m_v};
            r_out_v <= r_dv_v[QW-1];
        end
    end

    // Carry item data beside the root and divide pipelines
    always_ff @(posedge i_clk) begin
        r_sq_side[0] <= f_side;
        for (int k = 1; k < RW; k++) begin
            r_sq_side[k] <= r_sq_side[k-1];
        end
        r_dv_side[0] <= r_m_side;
        for (int k = 1; k < QW; k++) begin
            r_dv_side[k] <= r_dv_side[k-1];
        end
    end

    // Overlap, then per-axis products and doubled distance
    always_ff @(posedge i_clk) begin
        r_o_side <= r_sq_side[RW-1];
        r_o_dist <= w_dist;
        r_o_ov   <= r_sq_side[RW-1].s - w_dist[W-1:0];
        r_m_side <= r_o_side;
        r_m_nx   <= NUMW'(r_o_side.mx) * NUMW'(r_o_ov);
        r_m_ny   <= NUMW'(r_o_side.my) * NUMW'(r_o_ov);
        r_m_den  <= {r_o_dist, 1'b0};
    end

    // Apply signed shifts and saturate
    always_comb begin
        n_px = r_dv_side[QW-1].neg_x ? -{2'b00, w_qx} : {2'b00, w_qx};
        n_py = r_dv_side[QW-1].neg_y ? -{2'b00, w_qy} : {2'b00, w_qy};
        n_out.touching     = r_dv_side[QW-1].touch;
        n_out.new_first_x  = r_dv_side[QW-1].ax;
        n_out.new_first_y  = r_dv_side[QW-1].ay;
        n_out.new_second_x = r_dv_side[QW-1].bx;
        n_out.new_second_y = r_dv_side[QW-1].by;
        if (r_dv_side[QW-1].move) begin
            n_out.new_first_x  = sat_coord({r_dv_side[QW-1].ax[W-1], r_dv_side[QW-1].ax} + n_px);
            n_out.new_first_y  = sat_coord({r_dv_side[QW-1].ay[W-1], r_dv_side[QW-1].ay} + n_py);
            n_out.new_second_x = sat_coord({r_dv_side[QW-1].bx[W-1], r_dv_side[QW-1].bx} - n_px);
            n_out.new_second_y = sat_coord({r_dv_side[QW-1].by[W-1], r_dv_side[QW-1].by} - n_py);
        end
    end

    // Hold the result for its strobe cycle
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_busy   = 1'b0;
    assign o_valid  = r_out_v;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_root_within_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && r_o_side.touch |-> {1'b0, r_o_dist} <= {2'b00, r_o_side.s})
        else $error("root exceeds radius sum on a touching item");
    a_pass_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.touching |->
            o_result.new_first_x == $past(i_item.first_x, LAT)
            && o_result.new_second_x == $past(i_item.second_x, LAT))
        else $error("non-touching item x changed");
    a_pass_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.touching |->
            o_result.new_first_y == $past(i_item.first_y, LAT)
            && o_result.new_second_y == $past(i_item.second_y, LAT))
        else $error("non-touching item y changed");
`endif
endmodule
`default_nettype wire

[design/cpcr_front.sv]
// Front pipeline: deltas, magnitudes, squares, squared distance and touch test.
`timescale 1ns / 1ps
`default_nettype none
module cpcr_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire cpcr_pkg::t_in        i_item,
    output logic                      o_valid,
    output cpcr_pkg::t_side           o_side,
    output logic [cpcr_pkg::D2W-1:0]  o_d2
);
    import cpcr_pkg::*;

    logic [4:0]         r_v;
    t_side              r_side1, r_side2, r_side3, r_side4, r_side5;
    t_side              n_side1, n_side2, n_side5;
    logic signed [W:0]  r_dx, r_dy, n_dx, n_dy;
    logic [W:0]         n_ax_full, n_ay_full;
    logic [2*W-1:0]     r_sx, r_sy, r_s2, r_s2_4;
    logic [D2W-1:0]     r_d2, r_d2_5;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // Stage one: deltas and radius sum
    always_comb begin
        n_dx = $signed({i_item.first_x[W-1], i_item.first_x})
             - $signed({i_item.second_x[W-1], i_item.second_x});
        n_dy = $signed({i_item.first_y[W-1], i_item.first_y})
             - $signed({i_item.second_y[W-1], i_item.second_y});
        n_side1 = '0;
        n_side1.ax = i_item.first_x;
        n_side1.ay = i_item.first_y;
        n_side1.bx = i_item.second_x;
        n_side1.by = i_item.second_y;
        n_side1.s  = {1'b0, i_item.first_radius} + {1'b0, i_item.second_radius};
    end

    // Stage two: magnitudes and signs
    always_comb begin
        n_ax_full = r_dx[W] ? (~r_dx + 1'b1) : r_dx;
        n_ay_full = r_dy[W] ? (~r_dy + 1'b1) : r_dy;
        n_side2 = r_side1;
        n_side2.neg_x = r_dx[W];
        n_side2.neg_y = r_dy[W];
        n_side2.mx = n_ax_full[W-1:0];
        n_side2.my = n_ay_full[W-1:0];
    end

    // Stage five: touch test against squared radius sum
    always_comb begin
        n_side5 = r_side4;
        n_side5.touch = (r_d2 <= {1'b0, r_s2_4});
        n_side5.move  = (r_d2 <= {1'b0, r_s2_4}) && (r_d2 != '0);
    end

    // Hold payload per stage
    always_ff @(posedge i_clk) begin
        r_side1 <= n_side1;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_side2 <= n_side2;
        r_sx    <= (2*W)'(r_side2.mx) * (2*W)'(r_side2.mx);
        r_sy    <= (2*W)'(r_side2.my) * (2*W)'(r_side2.my);
        r_s2    <= (2*W)'(r_side2.s) * (2*W)'(r_side2.s);
        r_side3 <= r_side2;
        r_d2    <= {1'b0, r_sx} + {1'b0, r_sy};
        r_s2_4  <= r_s2;
        r_side4 <= r_side3;
        r_side5 <= n_side5;
        r_d2_5  <= r_d2;
    end

    assign o_valid = r_v[4];
    assign o_side  = r_side5;
    assign o_d2    = r_d2_5;
endmodule
`default_nettype wire

[design/cpcr_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module cpcr_sqrt (
    input  wire logic                 i_clk,
    input  wire logic [cpcr_pkg::D2W-1:0] i_rad,
    output logic [cpcr_pkg::RW-1:0]   o_root
);
    import cpcr_pkg::*;

    localparam int REMW = RW + 2;
    localparam int RADW = 2 * RW;

    logic [REMW-1:0] r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [RADW-1:0] r_rad  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [REMW-1:0] p_rem, sh, trial;
        logic [RW-1:0]   p_root;
        logic [RADW-1:0] p_rad;
        logic            ge;

        // Take the previous stage, or the input at the head
        if (k == 0) begin : g_head
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = {{(RADW-D2W){1'b0}}, i_rad};
        end else begin : g_body
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
        end

        // Bring down two radicand bits and try the next root bit
        assign sh    = {p_rem[REMW-3:0], p_rad[RADW-1:RADW-2]};
        assign trial = {p_root, 2'b01};
        assign ge    = (sh >= trial);

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? (sh - trial) : sh;
            r_root[k] <= {p_root[RW-2:0], ge};
            r_rad[k]  <= {p_rad[RADW-3:0], 2'b00};
        end
    end

    assign o_root = r_root[RW-1];
endmodule
`default_nettype wire

[design/cpcr_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module cpcr_div (
    input  wire logic                      i_clk,
    input  wire logic [cpcr_pkg::NUMW-1:0] i_num,
    input  wire logic [cpcr_pkg::DENW-1:0] i_den,
    output logic [cpcr_pkg::QW-1:0]        o_quo
);
    import cpcr_pkg::*;

    localparam int REMW = DENW + 1;

    logic [REMW-1:0] r_rem [QW];
    logic [QW-1:0]   r_lo  [QW];
    logic [QW-1:0]   r_quo [QW];
    logic [DENW-1:0] r_den [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [REMW-1:0] p_rem, sh;
        logic [QW-1:0]   p_lo, p_quo;
        logic [DENW-1:0] p_den;
        logic            ge;

        // The quotient fits QW bits, so the top bits start below the divisor
        if (k == 0) begin : g_head
            assign p_rem = {{(REMW-(NUMW-QW)){1'b0}}, i_num[NUMW-1:QW]};
            assign p_lo  = i_num[QW-1:0];
            assign p_quo = '0;
            assign p_den = i_den;
        end else begin : g_body
            assign p_rem = r_rem[k-1];
            assign p_lo  = r_lo[k-1];
            assign p_quo = r_quo[k-1];
            assign p_den = r_den[k-1];
        end

        // Shift in one numerator bit and subtract where it fits
        assign sh = {p_rem[REMW-2:0], p_lo[QW-1]};
        assign ge = (sh >= {1'b0, p_den});

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? (sh - {1'b0, p_den}) : sh;
            r_lo[k]  <= {p_lo[QW-2:0], 1'b0};
            r_quo[k] <= {p_quo[QW-2:0], ge};
            r_den[k] <= p_den;
        end
    end

    assign o_quo = r_quo[QW-1];
endmodule
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the circle pair collision resolve unit.
`timescale 1ns / 1ps
module tb;
    import cpcr_pkg::*;

    localparam int LATENCY   = 56;
    localparam int MAX_CYCLE = 400000;
    localparam int N_RANDOM  = 1100;
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-2:0]        RMAX = {(W-1){1'b1}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_in  i_item = '0;
    logic o_busy;
    logic o_valid;
    t_out o_result;

    circle_pair_collision_resolve_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .o_busy(o_busy), .o_valid(o_valid), .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_out pending_moves[$];
    int   errors = 0;
    int   cycle = 0;

    // Integer square root, floor
    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned root, bit_v;
        root = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= root + bit_v) begin
                n -= root + bit_v;
                root = (root >> 1) + bit_v;
            end else begin
                root >>= 1;
            end
            bit_v >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [W-1:0] clamp(input longint v);
        if (v > longint'(CMAX)) return CMAX;
        if (v < longint'(CMIN)) return CMIN;
        return v[W-1:0];
    endfunction

    // Expected corrected pair for one item
    function automatic t_out resolve_pair(input t_in it);
        t_out r;
        longint ax, ay, bx, by, dx, dy, px, py;
        longint unsigned mx, my, d2, s, root_d, ov;
        ax = it.first_x; ay = it.first_y;
        bx = it.second_x; by = it.second_y;
        dx = ax - bx; dy = ay - by;
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        d2 = mx * mx + my * my;
        s = longint'(it.first_radius) + longint'(it.second_radius);
        r.touching = (d2 <= s * s);
        r.new_first_x = it.first_x; r.new_first_y = it.first_y;
        r.new_second_x = it.second_x; r.new_second_y = it.second_y;
        if (r.touching && d2 != 0) begin
            root_d = floor_root(d2);
            ov = s - root_d;
            px = (mx * ov) / (2 * root_d);
            py = (my * ov) / (2 * root_d);
            if (dx < 0) px = -px;
            if (dy < 0) py = -py;
            r.new_first_x = clamp(ax + px);
            r.new_first_y = clamp(ay + py);
            r.new_second_x = clamp(bx - px);
            r.new_second_y = clamp(by - py);
        end
        return r;
    endfunction

    // Directed table; hand-typed results where obvious
    typedef struct {
        t_in  item;
        logic has_known;
        t_out known;
    } t_row;
    t_row rows[$];

    task automatic add_row(input t_in it, input logic hk, input t_out kn);
        t_row rw;
        rw.item = it; rw.has_known = hk; rw.known = kn;
        rows.push_back(rw);
    endtask

    // Present one item; hold until accepted
    task automatic send_item(input t_in it, input t_out expected_move);
        i_item <= it;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_moves.push_back(expected_move);
    endtask

    task automatic idle_cycles(input int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic t_in random_pair(input int mode);
        t_in it;
        int span;
        it.first_x = W'($urandom); it.first_y = W'($urandom);
        it.second_x = W'($urandom); it.second_y = W'($urandom);
        it.first_radius = (W-1)'($urandom); it.second_radius = (W-1)'($urandom);
        if (mode < 6) begin
            // nearby pair, mostly overlapping
            span = 1 << $urandom_range(4, 20);
            it.second_x = W'(it.first_x + $signed($urandom_range(0, 2 * span)) - span);
            it.second_y = W'(it.first_y + $signed($urandom_range(0, 2 * span)) - span);
            it.first_radius = (W-1)'($urandom_range(0, span));
            it.second_radius = (W-1)'($urandom_range(0, span));
        end else if (mode == 6) begin
            // coincident centres
            it.second_x = it.first_x; it.second_y = it.first_y;
        end else if (mode == 7) begin
            // near the edges, large radii for saturation
            it.first_x = $urandom_range(0, 1) ? W'(CMAX - $urandom_range(0, 4095))
                                               : W'(CMIN + $urandom_range(0, 4095));
            it.second_x = W'(it.first_x + $signed($urandom_range(0, 8191)) - 4096);
            it.second_y = W'(it.first_y + $signed($urandom_range(0, 8191)) - 4096);
        end
        return it;
    endfunction

    // Check each result strobe against the oldest expectation
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (i_rst_n && o_valid) begin
            if (pending_moves.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                errors <= errors + 1;
            end else begin
                t_out e;
                e = pending_moves.pop_front();
                if (o_result.touching !== e.touching ||
                    o_result.new_first_x !== e.new_first_x ||
                    o_result.new_first_y !== e.new_first_y ||
                    o_result.new_second_x !== e.new_second_x ||
                    o_result.new_second_y !== e.new_second_y) begin
                    $display("%0t: expected %h actual %h", $time, e, o_result);
                    errors <= errors + 1;
                end
            end
        end
        if (cycle >= MAX_CYCLE) begin
            $display("circle_pair_collision_resolve_unit: mismatch");
            $finish;
        end
    end

    initial begin
        t_in  it;
        t_out kn;
        int   burst;
        int   wait_left;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all zero: coincident, touching, no move
        it = '0; kn = '0; kn.touching = 1'b1;
        add_row(it, 1'b1, kn);
        // far apart extremes, zero radii: untouched
        it = '0; it.first_x = CMIN; it.first_y = CMIN;
        it.second_x = CMAX; it.second_y = CMAX;
        kn = '0; kn.new_first_x = CMIN; kn.new_first_y = CMIN;
        kn.new_second_x = CMAX; kn.new_second_y = CMAX;
        add_row(it, 1'b1, kn);
        // far corners with max radii: still apart
        it.first_radius = RMAX; it.second_radius = RMAX;
        add_row(it, 1'b0, kn);
        it.first_x = CMAX; it.first_y = CMIN; it.second_x = CMIN; it.second_y = CMAX;
        add_row(it, 1'b0, kn);
        // coincident at the max with max radii
        it.first_x = CMAX; it.first_y = CMAX; it.second_x = CMAX; it.second_y = CMAX;
        kn = '0; kn.touching = 1'b1;
        kn.new_first_x = CMAX; kn.new_first_y = CMAX;
        kn.new_second_x = CMAX; kn.new_second_y = CMAX;
        add_row(it, 1'b1, kn);
        // exactly touching on x and on y, one unit apart
        it = '0; it.first_x = 24'sd8192; it.first_radius = 23'd4096;
        it.second_radius = 23'd4096;
        add_row(it, 1'b0, kn);
        it = '0; it.first_y = -24'sd3; it.second_radius = 23'd3;
        add_row(it, 1'b0, kn);
        it = '0; it.first_x = 24'sd1; it.first_radius = 23'd1;
        add_row(it, 1'b0, kn);
        // just missing
        it = '0; it.first_x = 24'sd8193; it.first_radius = 23'd4096;
        it.second_radius = 23'd4096;
        add_row(it, 1'b0, kn);
        // diagonal overlap, both signs
        it = '0; it.first_x = -24'sd3000; it.first_y = 24'sd4000;
        it.second_x = 24'sd100; it.second_y = -24'sd200;
        it.first_radius = 23'd9000; it.second_radius = 23'd7000;
        add_row(it, 1'b0, kn);
        it.first_x = 24'sd5000; it.second_x = -24'sd5000; it.first_y = -24'sd1;
        add_row(it, 1'b0, kn);

        foreach (rows[k]) begin
            kn = resolve_pair(rows[k].item);
            if (rows[k].has_known && kn !== rows[k].known)
                $display("%0t: expected %h actual %h", $time, rows[k].known, kn);
            send_item(rows[k].item, rows[k].has_known ? rows[k].known : kn);
        end

        // hold until the pipeline drains once
        i_start <= 1'b0;
        wait_left = 0;
        while (pending_moves.size() != 0 && wait_left < 10 * LATENCY) begin
            @(posedge i_clk);
            wait_left++;
        end

        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
                it = random_pair($urandom_range(0, 9));
                send_item(it, resolve_pair(it));
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
        end
        i_start <= 1'b0;

        // drain, then let the pipeline run idle before the verdict
        wait_left = 0;
        while (pending_moves.size() != 0 && wait_left < 20 * LATENCY) begin
            @(posedge i_clk);
            wait_left++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        if (errors == 0 && pending_moves.size() == 0) begin
            $display("circle_pair_collision_resolve_unit: match");
        end else begin
            $display("circle_pair_collision_resolve_unit: mismatch");
        end
        $finish;
    end
endmodule

[circle_pair_collision_resolve_unit.f]
design/cpcr_pkg.sv
design/cpcr_front.sv
design/cpcr_sqrt.sv
design/cpcr_div.sv
design/circle_pair_collision_resolve_unit.sv
dv/tb.sv
